FILE: design/tsrs_pkg.sv
// Shared constants, control-word types and the microprogram of the slot rotation scheduler.
package tsrs_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int SLOT_COUNT_DEF  = 16;
    localparam int TOP_RATE_HZ_DEF = 1000;

    // Effect ids: the port is 8 bits, the stored identity keeps ID_BITS of them
    localparam int ID_BITS = 8;
    localparam int ID_W    = 8;
    localparam logic [ID_W-1:0] ID_MASK =
        (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << ID_BITS) - 1);

    localparam int MS_PER_S   = 1000;
    localparam int RUN_SLOT_W = 4;

    // Interval divider width: numerator 2*MS_PER_S + rate, divisor 2*rate
    localparam int DIV_W = 17;

    // Microprogram address width
    localparam int STEP_W = 5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;
    localparam logic [1:0] ST_NO_ID   = 2'd3;

    // Action codes
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_REG_IDX   = 3'd1;
    localparam logic [2:0] ACT_REG_NEXT  = 3'd2;
    localparam logic [2:0] ACT_FORCE_IDX = 3'd3;
    localparam logic [2:0] ACT_FORCE_ID  = 3'd4;

    // Microprogram entry points
    localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] S_DISP      = 5'd1;
    localparam logic [STEP_W-1:0] S_T_RD      = 5'd2;
    localparam logic [STEP_W-1:0] S_T_EVAL    = 5'd3;
    localparam logic [STEP_W-1:0] S_T_ROT     = 5'd4;
    localparam logic [STEP_W-1:0] S_T_FRC     = 5'd5;
    localparam logic [STEP_W-1:0] S_T_TAKE    = 5'd6;
    localparam logic [STEP_W-1:0] S_SCAN_INIT = 5'd7;
    localparam logic [STEP_W-1:0] S_SCAN_RD   = 5'd8;
    localparam logic [STEP_W-1:0] S_SCAN_CHK  = 5'd9;
    localparam logic [STEP_W-1:0] S_SCAN_NXT  = 5'd10;
    localparam logic [STEP_W-1:0] S_SCAN_MISS = 5'd11;
    localparam logic [STEP_W-1:0] S_RUN_RD    = 5'd12;
    localparam logic [STEP_W-1:0] S_RUN       = 5'd13;
    localparam logic [STEP_W-1:0] S_REG_IDX   = 5'd14;
    localparam logic [STEP_W-1:0] S_REG_NXT   = 5'd15;
    localparam logic [STEP_W-1:0] S_REG_CHK   = 5'd16;
    localparam logic [STEP_W-1:0] S_REG_WAIT  = 5'd17;
    localparam logic [STEP_W-1:0] S_REG_WR    = 5'd18;
    localparam logic [STEP_W-1:0] S_REJECT    = 5'd19;
    localparam logic [STEP_W-1:0] S_F_IDX     = 5'd20;
    localparam logic [STEP_W-1:0] S_FID_INIT  = 5'd21;
    localparam logic [STEP_W-1:0] S_FID_RD    = 5'd22;
    localparam logic [STEP_W-1:0] S_FID_CHK   = 5'd23;
    localparam logic [STEP_W-1:0] S_FID_NXT   = 5'd24;
    localparam logic [STEP_W-1:0] S_FID_MISS  = 5'd25;
    localparam logic [STEP_W-1:0] S_REPORT    = 5'd26;
    localparam logic [STEP_W-1:0] S_FIN       = 5'd31;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLEAR,
        OP_RD_CUR,
        OP_EVAL_ROT,
        OP_TAKE_FORCE,
        OP_SCAN_INIT,
        OP_RD_PTR,
        OP_SCAN_STEP,
        OP_SCAN_MISS,
        OP_RUN,
        OP_SEL_IDX,
        OP_SEL_NEXT,
        OP_DIV_START,
        OP_WRITE,
        OP_REJECT,
        OP_FORCE_IDX,
        OP_FID_INIT,
        OP_FID_STEP,
        OP_FID_MISS,
        OP_FINISH
    } tsrs_op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_IN,
        J_DISPATCH,
        J_NO_ROT,
        J_NO_FORCE,
        J_SLOT_HIT,
        J_SCAN_MORE,
        J_REG_BAD,
        J_DIV_BUSY,
        J_ID_HIT,
        J_OUT_BUSY
    } tsrs_cond_t;

    typedef struct packed {
        tsrs_op_t          op;
        tsrs_cond_t        cond;
        logic [STEP_W-1:0] target;
    } tsrs_ctrl_t;

    // Status from the datapath that the sequencer branches on
    typedef struct packed {
        logic       in_valid;
        logic [2:0] action;
        logic       no_rot;
        logic       no_force;
        logic       slot_hit;
        logic       id_hit;
        logic       scan_more;
        logic       reg_bad;
        logic       div_busy;
        logic       out_busy;
    } tsrs_flags_t;

    // Control store
    function automatic tsrs_ctrl_t ucode(input logic [STEP_W-1:0] step);
        tsrs_ctrl_t w;
        unique case (step)
            S_IDLE:      w = '{OP_LATCH,      J_NO_IN,     S_IDLE};
            S_DISP:      w = '{OP_CLEAR,      J_DISPATCH,  S_IDLE};
            S_T_RD:      w = '{OP_RD_CUR,     J_NEXT,      S_IDLE};
            S_T_EVAL:    w = '{OP_EVAL_ROT,   J_NEXT,      S_IDLE};
            S_T_ROT:     w = '{OP_NONE,       J_NO_ROT,    S_RUN_RD};
            S_T_FRC:     w = '{OP_NONE,       J_NO_FORCE,  S_SCAN_INIT};
            S_T_TAKE:    w = '{OP_TAKE_FORCE, J_ALWAYS,    S_RUN_RD};
            S_SCAN_INIT: w = '{OP_SCAN_INIT,  J_NEXT,      S_IDLE};
            S_SCAN_RD:   w = '{OP_RD_PTR,     J_NEXT,      S_IDLE};
            S_SCAN_CHK:  w = '{OP_SCAN_STEP,  J_SLOT_HIT,  S_RUN_RD};
            S_SCAN_NXT:  w = '{OP_NONE,       J_SCAN_MORE, S_SCAN_RD};
            S_SCAN_MISS: w = '{OP_SCAN_MISS,  J_NEXT,      S_IDLE};
            S_RUN_RD:    w = '{OP_RD_CUR,     J_NEXT,      S_IDLE};
            S_RUN:       w = '{OP_RUN,        J_ALWAYS,    S_FIN};
            S_REG_IDX:   w = '{OP_SEL_IDX,    J_ALWAYS,    S_REG_CHK};
            S_REG_NXT:   w = '{OP_SEL_NEXT,   J_NEXT,      S_IDLE};
            S_REG_CHK:   w = '{OP_DIV_START,  J_REG_BAD,   S_REJECT};
            S_REG_WAIT:  w = '{OP_NONE,       J_DIV_BUSY,  S_REG_WAIT};
            S_REG_WR:    w = '{OP_WRITE,      J_ALWAYS,    S_REPORT};
            S_REJECT:    w = '{OP_REJECT,     J_ALWAYS,    S_REPORT};
            S_F_IDX:     w = '{OP_FORCE_IDX,  J_ALWAYS,    S_REPORT};
            S_FID_INIT:  w = '{OP_FID_INIT,   J_NEXT,      S_IDLE};
            S_FID_RD:    w = '{OP_RD_PTR,     J_NEXT,      S_IDLE};
            S_FID_CHK:   w = '{OP_FID_STEP,   J_ID_HIT,    S_REPORT};
            S_FID_NXT:   w = '{OP_NONE,       J_SCAN_MORE, S_FID_RD};
            S_FID_MISS:  w = '{OP_FID_MISS,   J_NEXT,      S_IDLE};
            S_REPORT:    w = '{OP_RD_CUR,     J_ALWAYS,    S_FIN};
            // the last word falls through to address zero once the result is loaded into the output register
            S_FIN:       w = '{OP_FINISH,     J_OUT_BUSY,  S_FIN};
            default:     w = '{OP_NONE,       J_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

    // Entry point for each action; unused actions only report
    function automatic logic [STEP_W-1:0] dispatch_entry(input logic [2:0] action);
        logic [STEP_W-1:0] e;
        unique case (action)
            ACT_TICK:      e = S_T_RD;
            ACT_REG_IDX:   e = S_REG_IDX;
            ACT_REG_NEXT:  e = S_REG_NXT;
            ACT_FORCE_IDX: e = S_F_IDX;
            ACT_FORCE_ID:  e = S_FID_INIT;
            default:       e = S_REPORT;
        endcase
        return e;
    endfunction

endpackage

FILE: design/tsrs_seq.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module tsrs_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsrs_pkg::tsrs_flags_t flags,
    output tsrs_pkg::tsrs_ctrl_t  ctrl
);

    logic [tsrs_pkg::STEP_W-1:0] step_reg;
    logic [tsrs_pkg::STEP_W-1:0] step_next;
    logic                        take;

    // Fetch the control word of the current step
    assign ctrl = tsrs_pkg::ucode(step_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            tsrs_pkg::J_NEXT:      take = 1'b0;
            tsrs_pkg::J_ALWAYS:    take = 1'b1;
            tsrs_pkg::J_NO_IN:     take = !flags.in_valid;
            tsrs_pkg::J_DISPATCH:  take = 1'b1;
            tsrs_pkg::J_NO_ROT:    take = flags.no_rot;
            tsrs_pkg::J_NO_FORCE:  take = flags.no_force;
            tsrs_pkg::J_SLOT_HIT:  take = flags.slot_hit;
            tsrs_pkg::J_SCAN_MORE: take = flags.scan_more;
            tsrs_pkg::J_REG_BAD:   take = flags.reg_bad;
            tsrs_pkg::J_DIV_BUSY:  take = flags.div_busy;
            tsrs_pkg::J_ID_HIT:    take = flags.id_hit;
            tsrs_pkg::J_OUT_BUSY:  take = flags.out_busy;
            default:               take = 1'b0;
        endcase
    end

    // Pick the next step: jump target, action dispatch or fall through
    always_comb
    begin
        if (!take)
        begin
            step_next = step_reg + 1'b1;
        end
        else if (ctrl.cond == tsrs_pkg::J_DISPATCH)
        begin
            step_next = tsrs_pkg::dispatch_entry(flags.action);
        end
        else
        begin
            step_next = ctrl.target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tsrs_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: design/tsrs_div.sv
// Iterative restoring divider for the run interval, one quotient bit per cycle.
module tsrs_div #(
    parameter int W = tsrs_pkg::DIV_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] numer,
    input  logic [W-1:0] denom,
    output logic         busy,
    output logic [W-1:0] quot
);

    localparam int CntW = $clog2(W + 1);

    logic            busy_reg;
    logic [CntW-1:0] cnt_reg;
    logic [W:0]      rem_reg;
    logic [W-1:0]    q_reg;
    logic [W-1:0]    den_reg;
    logic [W:0]      shifted;
    logic            ge;

    // Shift in the next numerator bit and trial-subtract
    assign shifted = {rem_reg[W-1:0], q_reg[W-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    assign busy = busy_reg;
    assign quot = q_reg;

    // Hold iteration count and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CntW'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CntW'(1));
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= numer;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
            q_reg   <= {q_reg[W-2:0], ge};
        end
    end

endmodule

FILE: design/tsrs_slot_mem.sv
// Slot table memory: effect id, dwell and interval per slot, one write and one registered read.
module tsrs_slot_mem #(
    parameter  int SLOT_COUNT = tsrs_pkg::SLOT_COUNT_DEF,
    localparam int AddrW      = $clog2(SLOT_COUNT)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [AddrW-1:0]         wr_addr,
    input  logic [tsrs_pkg::ID_W-1:0] wr_id,
    input  logic [31:0]              wr_dwell,
    input  logic [31:0]              wr_interval,
    input  logic                     rd_en,
    input  logic [AddrW-1:0]         rd_addr,
    output logic [tsrs_pkg::ID_W-1:0] rd_id,
    output logic [31:0]              rd_dwell,
    output logic [31:0]              rd_interval
);

    logic [tsrs_pkg::ID_W-1:0] id_mem       [SLOT_COUNT];
    logic [31:0]               dwell_mem    [SLOT_COUNT];
    logic [31:0]               interval_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]     valid_reg;
    logic                      rd_valid_reg;
    logic [tsrs_pkg::ID_W-1:0] rd_id_reg;
    logic [31:0]               rd_dwell_reg;
    logic [31:0]               rd_interval_reg;

    // Track written slots; an unwritten slot reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Write and read the storage arrays
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]       <= wr_id;
            dwell_mem[wr_addr]    <= wr_dwell;
            interval_mem[wr_addr] <= wr_interval;
        end
        if (rd_en)
        begin
            rd_id_reg       <= id_mem[rd_addr];
            rd_dwell_reg    <= dwell_mem[rd_addr];
            rd_interval_reg <= interval_mem[rd_addr];
        end
    end

    assign rd_id       = rd_valid_reg ? rd_id_reg : '0;
    assign rd_dwell    = rd_valid_reg ? rd_dwell_reg : '0;
    assign rd_interval = rd_valid_reg ? rd_interval_reg : '0;

endmodule

FILE: design/timed_slot_rotation_scheduler_core.sv
// Top level of the timed slot rotation scheduler: datapath, slot table, divider and sequencer.
//
// Every accepted beat yields exactly one result beat. Items are handled one at a time by a
// microprogram that drives a slot table with one write and one read port, so the cost is
// set by table reads and by the interval divider. A tick reads the current slot; it stays,
// takes a pending force, or searches for the next occupied slot, reading one slot after
// another. Registration waits for the divider, force by id searches the table for the id,
// and force by index and unused actions report directly. The result sits in an output
// register, so the next beat is accepted while an earlier result waits to be taken. The
// slot table comes out of reset empty at once; no clearing pass is needed.
module timed_slot_rotation_scheduler_core #(
    parameter int SLOT_COUNT  = tsrs_pkg::SLOT_COUNT_DEF,
    parameter int TOP_RATE_HZ = tsrs_pkg::TOP_RATE_HZ_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         action,
    input  logic [31:0]                        now_ms,
    input  logic                               leds_busy,
    input  logic signed [7:0]                  slot_index,
    input  logic signed [15:0]                 rate_hz,
    input  logic [31:0]                        dwell_ms,
    input  logic [7:0]                         effect_id,
    input  logic                               immediate,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               run_effect,
    output logic [tsrs_pkg::RUN_SLOT_W-1:0]    run_slot,
    output logic [7:0]                         run_id,
    output logic                               switched,
    output logic [1:0]                         status
);

    localparam int SlotW = $clog2(SLOT_COUNT);
    localparam int CntW  = $clog2(SLOT_COUNT + 1);
    localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOT_COUNT - 1);
    localparam logic signed [15:0] TopRate = 16'(TOP_RATE_HZ);

    tsrs_pkg::tsrs_ctrl_t  ctrl;
    tsrs_pkg::tsrs_flags_t flags;

    // Latched item
    logic [2:0]                action_reg;
    logic [31:0]               now_reg;
    logic                      leds_busy_reg;
    logic [7:0]                idx_reg;
    logic signed [15:0]        rate_reg;
    logic [31:0]               dwell_reg;
    logic [tsrs_pkg::ID_W-1:0] id_reg;
    logic                      imm_reg;

    // Scheduler state
    logic [SlotW-1:0] cur_reg, cur_next;
    logic [31:0]      last_switch_reg, last_switch_next;
    logic [31:0]      last_run_reg, last_run_next;
    logic             force_pending_reg, force_pending_next;
    logic [SlotW-1:0] force_slot_reg, force_slot_next;
    logic             force_now_reg, force_now_next;
    logic [7:0]       next_slot_reg, next_slot_next;

    // Working registers of the microprogram
    logic             rot_reg, rot_next;
    logic [SlotW-1:0] ptr_reg, ptr_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [8:0]       wr_idx_reg, wr_idx_next;
    logic             run_reg, run_next;
    logic             sw_reg, sw_next;
    logic [1:0]       status_reg, status_next;

    // Output register
    logic                            out_valid_reg, out_valid_next;
    logic                            out_run_effect_reg;
    logic [tsrs_pkg::RUN_SLOT_W-1:0] out_run_slot_reg;
    logic [7:0]                      out_run_id_reg;
    logic                            out_switched_reg;
    logic [1:0]                      out_status_reg;

    // Slot table and divider ports
    logic                      mem_wr_en;
    logic                      mem_rd_en;
    logic [SlotW-1:0]          mem_rd_addr;
    logic [tsrs_pkg::ID_W-1:0] rd_id;
    logic [31:0]               rd_dwell;
    logic [31:0]               rd_interval;
    logic                      div_start;
    logic                      div_busy;
    logic [tsrs_pkg::DIV_W-1:0] div_numer;
    logic [tsrs_pkg::DIV_W-1:0] div_denom;
    logic [tsrs_pkg::DIV_W-1:0] div_quot;

    // Derived values
    logic signed [15:0] rate_c;
    logic [31:0]        interval_w;
    logic [SlotW-1:0]   ptr_wrap;
    logic [SlotW-1:0]   cur_wrap;
    logic [SlotW-1:0]   idx_clamped;
    logic [31:0]        since_switch;
    logic [31:0]        since_run;
    logic               reg_bad;
    logic               slot_hit;
    logic               id_hit;
    logic               out_busy;
    logic               in_fire;
    logic               out_load;

    // Limit the rate and form the divider operands
    assign rate_c    = (rate_reg > TopRate) ? TopRate : rate_reg;
    assign div_numer = tsrs_pkg::DIV_W'(2 * tsrs_pkg::MS_PER_S) + tsrs_pkg::DIV_W'(rate_c[14:0]);
    assign div_denom = tsrs_pkg::DIV_W'({rate_c[14:0], 1'b0});
    assign div_start = (ctrl.op == tsrs_pkg::OP_DIV_START);

    // Interval: zero at the top rate, all ones at rate zero, else the rounded quotient
    always_comb
    begin
        if (rate_c == TopRate)
        begin
            interval_w = '0;
        end
        else if (rate_c == 16'sd0)
        begin
            interval_w = '1;
        end
        else
        begin
            interval_w = 32'(div_quot);
        end
    end

    // Registration target must lie in the table and the rate must not be negative
    assign reg_bad = wr_idx_reg[8] || (wr_idx_reg[7:0] >= 8'(SLOT_COUNT)) || rate_c[15];

    // Slot pointer arithmetic with wrap-around
    assign ptr_wrap = (ptr_reg == LastSlot) ? '0 : ptr_reg + 1'b1;
    assign cur_wrap = (cur_reg == LastSlot) ? '0 : cur_reg + 1'b1;

    // Clamp the signed force index into the table
    always_comb
    begin
        if (idx_reg[7])
        begin
            idx_clamped = '0;
        end
        else if (idx_reg > 8'(SLOT_COUNT - 1))
        begin
            idx_clamped = LastSlot;
        end
        else
        begin
            idx_clamped = SlotW'(idx_reg);
        end
    end

    assign since_switch = now_reg - last_switch_reg;
    assign since_run    = now_reg - last_run_reg;
    assign slot_hit     = (rd_id != '0);
    assign id_hit       = (rd_id == id_reg);
    assign out_busy     = out_valid_reg && !out_ready;
    assign in_ready     = (ctrl.op == tsrs_pkg::OP_LATCH);
    assign in_fire      = in_valid && in_ready;
    assign out_load     = (ctrl.op == tsrs_pkg::OP_FINISH) && !out_busy;

    // Table access
    assign mem_wr_en   = (ctrl.op == tsrs_pkg::OP_WRITE);
    assign mem_rd_en   = (ctrl.op == tsrs_pkg::OP_RD_CUR) || (ctrl.op == tsrs_pkg::OP_RD_PTR);
    assign mem_rd_addr = (ctrl.op == tsrs_pkg::OP_RD_PTR) ? ptr_reg : cur_reg;

    // Branch status for the sequencer
    always_comb
    begin
        flags.in_valid  = in_valid;
        flags.action    = action_reg;
        flags.no_rot    = !rot_reg;
        flags.no_force  = !force_pending_reg;
        flags.slot_hit  = slot_hit;
        flags.id_hit    = id_hit;
        flags.scan_more = (cnt_reg != CntW'(SLOT_COUNT));
        flags.reg_bad   = reg_bad;
        flags.div_busy  = div_busy;
        flags.out_busy  = out_busy;
    end

    // Execute the datapath operation of the current step
    always_comb
    begin
        cur_next           = cur_reg;
        last_switch_next   = last_switch_reg;
        last_run_next      = last_run_reg;
        force_pending_next = force_pending_reg;
        force_slot_next    = force_slot_reg;
        force_now_next     = force_now_reg;
        next_slot_next     = next_slot_reg;
        rot_next           = rot_reg;
        ptr_next           = ptr_reg;
        cnt_next           = cnt_reg;
        wr_idx_next        = wr_idx_reg;
        run_next           = run_reg;
        sw_next            = sw_reg;
        status_next        = status_reg;
        out_valid_next     = out_valid_reg && !out_ready;

        unique case (ctrl.op)
            tsrs_pkg::OP_CLEAR:
            begin
                run_next    = 1'b0;
                sw_next     = 1'b0;
                status_next = tsrs_pkg::ST_OK;
            end
            tsrs_pkg::OP_EVAL_ROT:
            begin
                rot_next = (since_switch >= rd_dwell) || force_now_reg;
            end
            tsrs_pkg::OP_TAKE_FORCE:
            begin
                cur_next           = force_slot_reg;
                sw_next            = (force_slot_reg != cur_reg);
                force_pending_next = 1'b0;
                force_now_next     = 1'b0;
                last_switch_next   = now_reg;
            end
            tsrs_pkg::OP_SCAN_INIT:
            begin
                ptr_next = cur_wrap;
                cnt_next = '0;
            end
            tsrs_pkg::OP_SCAN_STEP:
            begin
                if (slot_hit)
                begin
                    cur_next         = ptr_reg;
                    sw_next          = (ptr_reg != cur_reg);
                    force_now_next   = 1'b0;
                    last_switch_next = now_reg;
                end
                else
                begin
                    ptr_next = ptr_wrap;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tsrs_pkg::OP_SCAN_MISS:
            begin
                status_next      = tsrs_pkg::ST_NO_SLOT;
                force_now_next   = 1'b0;
                last_switch_next = now_reg;
            end
            tsrs_pkg::OP_RUN:
            begin
                if (!leds_busy_reg && ((rd_interval == '0) || (since_run >= rd_interval)))
                begin
                    run_next      = 1'b1;
                    last_run_next = now_reg;
                end
            end
            tsrs_pkg::OP_SEL_IDX:
            begin
                wr_idx_next = {idx_reg[7], idx_reg};
            end
            tsrs_pkg::OP_SEL_NEXT:
            begin
                wr_idx_next = {1'b0, next_slot_reg};
                if (next_slot_reg != 8'hFF)
                begin
                    next_slot_next = next_slot_reg + 1'b1;
                end
            end
            tsrs_pkg::OP_REJECT:
            begin
                status_next = tsrs_pkg::ST_REJECT;
            end
            tsrs_pkg::OP_FORCE_IDX:
            begin
                force_slot_next    = idx_clamped;
                force_pending_next = 1'b1;
                force_now_next     = imm_reg;
            end
            tsrs_pkg::OP_FID_INIT:
            begin
                ptr_next = '0;
                cnt_next = '0;
            end
            tsrs_pkg::OP_FID_STEP:
            begin
                if (id_hit)
                begin
                    force_slot_next    = ptr_reg;
                    force_pending_next = 1'b1;
                    force_now_next     = imm_reg;
                end
                else
                begin
                    ptr_next = ptr_wrap;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tsrs_pkg::OP_FID_MISS:
            begin
                force_slot_next    = '0;
                force_pending_next = 1'b1;
                force_now_next     = imm_reg;
                status_next        = tsrs_pkg::ST_NO_ID;
            end
            tsrs_pkg::OP_FINISH:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg           <= '0;
            last_switch_reg   <= '0;
            last_run_reg      <= '0;
            force_pending_reg <= 1'b0;
            force_slot_reg    <= '0;
            force_now_reg     <= 1'b0;
            next_slot_reg     <= '0;
            rot_reg           <= 1'b0;
            ptr_reg           <= '0;
            cnt_reg           <= '0;
            wr_idx_reg        <= '0;
            run_reg           <= 1'b0;
            sw_reg            <= 1'b0;
            status_reg        <= tsrs_pkg::ST_OK;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            cur_reg           <= cur_next;
            last_switch_reg   <= last_switch_next;
            last_run_reg      <= last_run_next;
            force_pending_reg <= force_pending_next;
            force_slot_reg    <= force_slot_next;
            force_now_reg     <= force_now_next;
            next_slot_reg     <= next_slot_next;
            rot_reg           <= rot_next;
            ptr_reg           <= ptr_next;
            cnt_reg           <= cnt_next;
            wr_idx_reg        <= wr_idx_next;
            run_reg           <= run_next;
            sw_reg            <= sw_next;
            status_reg        <= status_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Capture the input beat and load the result beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg    <= action;
            now_reg       <= now_ms;
            leds_busy_reg <= leds_busy;
            idx_reg       <= slot_index;
            rate_reg      <= rate_hz;
            dwell_reg     <= dwell_ms;
            id_reg        <= effect_id & tsrs_pkg::ID_MASK;
            imm_reg       <= immediate;
        end
        if (out_load)
        begin
            out_run_effect_reg <= run_reg;
            out_run_slot_reg   <= tsrs_pkg::RUN_SLOT_W'(cur_reg);
            out_run_id_reg     <= 8'(rd_id);
            out_switched_reg   <= sw_reg;
            out_status_reg     <= status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign run_effect = out_run_effect_reg;
    assign run_slot   = out_run_slot_reg;
    assign run_id     = out_run_id_reg;
    assign switched   = out_switched_reg;
    assign status     = out_status_reg;

    tsrs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    tsrs_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (mem_wr_en),
        .wr_addr     (SlotW'(wr_idx_reg[7:0])),
        .wr_id       (id_reg),
        .wr_dwell    (dwell_reg),
        .wr_interval (interval_w),
        .rd_en       (mem_rd_en),
        .rd_addr     (mem_rd_addr),
        .rd_id       (rd_id),
        .rd_dwell    (rd_dwell),
        .rd_interval (rd_interval)
    );

    tsrs_div #(
        .W (tsrs_pkg::DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // One item at a time: the sequencer leaves idle right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    // A result appears only from the final microprogram step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == tsrs_pkg::OP_FINISH))
        else $error("result raised outside the finish step");

    // Run and switch come from ticks only, which never report registration or id codes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_run_effect_reg || out_switched_reg)) |->
        (out_status_reg == tsrs_pkg::ST_OK || out_status_reg == tsrs_pkg::ST_NO_SLOT))
        else $error("tick flags with a non-tick status");

    // Slot searches never visit more slots than the table holds
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(SLOT_COUNT))
        else $error("slot search overran the table");

endmodule

FILE: tb/sv/tb_timed_slot_rotation_scheduler_core.sv
// Self-checking testbench for the timed slot rotation scheduler core.
module tb_timed_slot_rotation_scheduler_core;
    import tsrs_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_BEATS = 450;
    localparam int DRAIN_CYCLES = 3 * SLOT_COUNT_DEF + 20;
    localparam int LIMIT_CYCLES = 600000;
    localparam int REPORT_MAX   = 10;
    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int TOP_RATE     = TOP_RATE_HZ_DEF;

    // Actions that the block only reports on
    localparam logic [2:0] ACT_SPARE5 = 3'd5;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now;
        logic        busy;
        logic [7:0]  idx;
        logic [15:0] rate;
        logic [31:0] dwell;
        logic [7:0]  id;
        logic        imm;
    } sched_beat_t;

    typedef struct packed {
        logic                  run;
        logic [RUN_SLOT_W-1:0] slot;
        logic [7:0]            id;
        logic                  sw;
        logic [1:0]            st;
    } sched_result_t;

    typedef struct {
        sched_beat_t   b;
        bit            typed;
        sched_result_t res;
    } sched_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            action;
    logic [31:0]           now_ms;
    logic                  leds_busy;
    logic signed [7:0]     slot_index;
    logic signed [15:0]    rate_hz;
    logic [31:0]           dwell_ms;
    logic [7:0]            effect_id;
    logic                  immediate;
    logic                  out_valid;
    logic                  out_ready;
    logic                  run_effect;
    logic [RUN_SLOT_W-1:0] run_slot;
    logic [7:0]            run_id;
    logic                  switched;
    logic [1:0]            status;

    // Shadow copy of the slot table and rotation state
    logic [7:0]  tbl_id [SLOTS];
    logic [31:0] tbl_dwell [SLOTS];
    logic [31:0] tbl_interval [SLOTS];
    logic [3:0]  cur_slot;
    logic [31:0] switch_ms;
    logic [31:0] ran_ms;
    logic        frc_pend;
    logic [3:0]  frc_slot;
    logic        frc_now;
    logic [7:0]  reg_cursor;

    sched_result_t want_q[$];
    sched_row_t    directed[$];
    logic [31:0]   sim_ms;
    int            fail_cnt = 0;
    bit            steady = 1'b0;

    timed_slot_rotation_scheduler_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .now_ms     (now_ms),
        .leds_busy  (leds_busy),
        .slot_index (slot_index),
        .rate_hz    (rate_hz),
        .dwell_ms   (dwell_ms),
        .effect_id  (effect_id),
        .immediate  (immediate),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .run_effect (run_effect),
        .run_slot   (run_slot),
        .run_id     (run_id),
        .switched   (switched),
        .status     (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic sched_beat_t mk_beat(input logic [2:0] a, input logic [31:0] now,
                                            input logic busy, input logic [7:0] idx,
                                            input logic [15:0] rate, input logic [31:0] dwell,
                                            input logic [7:0] id, input logic imm);
        sched_beat_t b;
        b = '{a, now, busy, idx, rate, dwell, id, imm};
        return b;
    endfunction

    task automatic add_row(input sched_beat_t b, input bit typed, input sched_result_t res);
        sched_row_t row;
        row.b     = b;
        row.typed = typed;
        row.res   = res;
        directed.push_back(row);
    endtask

    // Write one slot; reject a bad index or a negative rate
    function automatic logic [1:0] write_slot(input int index, input int rate,
                                              input logic [31:0] dwell, input logic [7:0] id);
        if (rate > TOP_RATE)
            rate = TOP_RATE;
        if (index < 0 || index >= SLOTS || rate < 0)
            return ST_REJECT;
        tbl_id[index]    = id & ID_MASK;
        tbl_dwell[index] = dwell;
        if (rate == TOP_RATE)
            tbl_interval[index] = 32'd0;
        else if (rate == 0)
            tbl_interval[index] = 32'hFFFF_FFFF;
        else
            tbl_interval[index] = 32'((2 * MS_PER_S + rate) / (2 * rate));
        return ST_OK;
    endfunction

    // Advance the shadow scheduler by one beat and return the result it gives
    function automatic sched_result_t schedule_step(input sched_beat_t b);
        sched_result_t r;
        int            idx;
        int            rate;
        int            s;
        int            nxt;
        bit            found;
        logic [3:0]    pick;
        idx  = int'($signed(b.idx));
        rate = int'($signed(b.rate));
        r    = '0;
        r.st = ST_OK;
        case (b.action)
            ACT_TICK:
            begin
                pick = cur_slot;
                if ((b.now - switch_ms) >= tbl_dwell[cur_slot] || frc_now)
                begin
                    if (frc_pend)
                    begin
                        pick     = frc_slot;
                        frc_pend = 1'b0;
                    end
                    else
                    begin
                        // search the next occupied slot, wrapping back to the current one
                        s     = int'(cur_slot);
                        found = 1'b0;
                        for (int i = 0; i < SLOTS && !found; i++)
                        begin
                            s = (s + 1) % SLOTS;
                            if (tbl_id[s] != 8'd0)
                                found = 1'b1;
                        end
                        if (found)
                            pick = 4'(s);
                        else
                            r.st = ST_NO_SLOT;
                    end
                    frc_now   = 1'b0;
                    switch_ms = b.now;
                    r.sw      = (pick != cur_slot);
                    cur_slot  = pick;
                end
                if (!b.busy && (tbl_interval[cur_slot] == 32'd0 ||
                                (b.now - ran_ms) >= tbl_interval[cur_slot]))
                begin
                    ran_ms = b.now;
                    r.run  = 1'b1;
                end
            end
            ACT_REG_IDX:
                r.st = write_slot(idx, rate, b.dwell, b.id);
            ACT_REG_NEXT:
            begin
                nxt = int'(reg_cursor);
                if (reg_cursor < 8'd255)
                    reg_cursor = reg_cursor + 8'd1;
                r.st = write_slot(nxt, rate, b.dwell, b.id);
            end
            ACT_FORCE_IDX:
            begin
                if (idx < 0)
                    idx = 0;
                if (idx > SLOTS - 1)
                    idx = SLOTS - 1;
                frc_slot = 4'(idx);
                frc_pend = 1'b1;
                frc_now  = b.imm;
            end
            ACT_FORCE_ID:
            begin
                // lowest slot holding the id; a miss forces slot zero
                found = 1'b0;
                s     = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && tbl_id[i] == (b.id & ID_MASK))
                    begin
                        found = 1'b1;
                        s     = i;
                    end
                end
                if (!found)
                    r.st = ST_NO_ID;
                frc_slot = 4'(s);
                frc_pend = 1'b1;
                frc_now  = b.imm;
            end
            default:
                ;
        endcase
        r.slot = cur_slot;
        r.id   = tbl_id[cur_slot];
        return r;
    endfunction

    // Random beat: mostly ticks on a running clock and sane registrations, some noise
    function automatic sched_beat_t random_beat();
        sched_beat_t b;
        int          pick;
        b.action = ACT_TICK;
        b.now    = $urandom;
        b.busy   = 1'($urandom_range(0, 1));
        b.idx    = 8'($urandom);
        b.rate   = 16'($urandom);
        b.dwell  = $urandom;
        b.id     = 8'($urandom);
        b.imm    = 1'($urandom_range(0, 1));
        pick     = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 49) == 0)
                sim_ms = sim_ms + $urandom;
            else
                sim_ms = sim_ms + $urandom_range(0, 25);
            b.now  = sim_ms;
            b.busy = ($urandom_range(0, 3) == 0);
        end
        else if (pick < 65)
        begin
            b.action = (pick < 58) ? ACT_REG_IDX : ACT_REG_NEXT;
            if ($urandom_range(0, 9) != 0)
                b.idx = 8'($urandom_range(0, SLOTS - 1));
            case ($urandom_range(0, 9))
                0, 1:    ;
                2:       b.rate = 16'(TOP_RATE);
                3:       b.rate = 16'd0;
                default: b.rate = 16'($urandom_range(1, 1100));
            endcase
            if ($urandom_range(0, 9) != 0)
                b.dwell = $urandom_range(0, 60);
            if ($urandom_range(0, 3) != 0)
                b.id = 8'($urandom_range(0, 8));
        end
        else if (pick < 75)
        begin
            b.action = ACT_FORCE_IDX;
            if ($urandom_range(0, 1) != 0)
                b.idx = 8'($urandom_range(0, SLOTS - 1));
        end
        else if (pick < 85)
        begin
            b.action = ACT_FORCE_ID;
            if ($urandom_range(0, 4) != 0)
                b.id = 8'($urandom_range(0, 8));
        end
        else if (pick < 88)
        begin
            b.action = 3'($urandom_range(ACT_SPARE5, ACT_SPARE7));
        end
        return b;
    endfunction

    // Drive one beat after an optional gap, hold it until taken, then queue its result
    task automatic offer(input sched_beat_t b, input int gap, input bit typed,
                         input sched_result_t typed_res);
        sched_result_t pred;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= b.action;
        now_ms     <= b.now;
        leds_busy  <= b.busy;
        slot_index <= b.idx;
        rate_hz    <= b.rate;
        dwell_ms   <= b.dwell;
        effect_id  <= b.id;
        immediate  <= b.imm;
        do
            @(posedge clk);
        while (!in_ready);
        pred = schedule_step(b);
        want_q.push_back(typed ? typed_res : pred);
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (want_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side: check each beat against the oldest expectation, stall at random
    initial
    begin : result_sink
        int            stall_left;
        sched_result_t got;
        sched_result_t want;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = '{run_effect, run_slot, run_id, switched, status};
                if (want_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("unexpected result run=%0d slot=%0d id=%0h sw=%0d st=%0d",
                                 got.run, got.slot, got.id, got.sw, got.st);
                end
                else
                begin
                    want = want_q.pop_front();
                    if (got !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display("mismatch exp %0d %0d %0h %0d %0d, got %0d %0d %0h %0d %0d",
                                     want.run, want.slot, want.id, want.sw, want.st,
                                     got.run, got.slot, got.id, got.sw, got.st);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        action     <= ACT_TICK;
        now_ms     <= '0;
        leds_busy  <= 1'b0;
        slot_index <= '0;
        rate_hz    <= '0;
        dwell_ms   <= '0;
        effect_id  <= '0;
        immediate  <= 1'b0;

        // reset state of the shadow scheduler
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_id[i]       = '0;
            tbl_dwell[i]    = '0;
            tbl_interval[i] = '0;
        end
        cur_slot   = '0;
        switch_ms  = '0;
        ran_ms     = '0;
        frc_pend   = 1'b0;
        frc_slot   = '0;
        frc_now    = 1'b0;
        reg_cursor = '0;

        // directed beats; fixed results only where obvious
        add_row(mk_beat(ACT_TICK, 32'd0, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b1,
                sched_result_t'{1'b1, 4'd0, 8'h00, 1'b0, ST_NO_SLOT});
        add_row(mk_beat(ACT_FORCE_ID, 32'd0, 1'b0, 8'd0, 16'd0, 32'd0, 8'h55, 1'b0), 1'b1,
                sched_result_t'{1'b0, 4'd0, 8'h00, 1'b0, ST_NO_ID});
        add_row(mk_beat(ACT_REG_IDX, 32'd0, 1'b0, 8'h80, 16'd100, 32'd7, 8'h11, 1'b0), 1'b1,
                sched_result_t'{1'b0, 4'd0, 8'h00, 1'b0, ST_REJECT});
        add_row(mk_beat(ACT_REG_IDX, 32'd0, 1'b0, 8'd16, 16'd100, 32'd7, 8'h11, 1'b0), 1'b1,
                sched_result_t'{1'b0, 4'd0, 8'h00, 1'b0, ST_REJECT});
        add_row(mk_beat(ACT_REG_IDX, 32'd0, 1'b0, 8'd3, 16'h8000, 32'd7, 8'h11, 1'b0), 1'b1,
                sched_result_t'{1'b0, 4'd0, 8'h00, 1'b0, ST_REJECT});
        add_row(mk_beat(ACT_REG_IDX, 32'd0, 1'b0, 8'd0, 16'h7FFF, 32'd5, 8'hFF, 1'b0), 1'b1,
                sched_result_t'{1'b0, 4'd0, 8'hFF, 1'b0, ST_OK});
        add_row(mk_beat(ACT_REG_IDX, 32'd0, 1'b0, 8'd15, 16'd0, 32'hFFFF_FFFF, 8'h01, 1'b0),
                1'b0, '0);
        add_row(mk_beat(ACT_REG_NEXT, 32'd0, 1'b0, 8'd0, 16'd1, 32'd0, 8'h22, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_REG_NEXT, 32'd0, 1'b0, 8'd0, 16'd3, 32'd10, 8'h33, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_REG_NEXT, 32'd0, 1'b0, 8'd0, 16'd999, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_TICK, 32'd10, 1'b1, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_TICK, 32'd20, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_FORCE_IDX, 32'd0, 1'b0, 8'h7F, 16'd0, 32'd0, 8'h00, 1'b1), 1'b0, '0);
        add_row(mk_beat(ACT_TICK, 32'd21, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_FORCE_IDX, 32'd0, 1'b0, 8'h80, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_TICK, 32'hFFFF_FFFF, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0),
                1'b0, '0);
        add_row(mk_beat(ACT_FORCE_ID, 32'd0, 1'b0, 8'd0, 16'd0, 32'd0, 8'h33, 1'b1), 1'b0, '0);
        add_row(mk_beat(ACT_TICK, 32'd5, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_SPARE5, 32'd0, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_SPARE6, 32'hFFFF_FFFF, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                        8'hFF, 1'b1), 1'b0, '0);
        add_row(mk_beat(ACT_SPARE7, 32'd0, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_FORCE_ID, 32'd0, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b1), 1'b0, '0);
        add_row(mk_beat(ACT_TICK, 32'd6, 1'b0, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_beat(ACT_REG_IDX, 32'd0, 1'b0, 8'h7F, 16'd1000, 32'd0, 8'h44, 1'b0),
                1'b0, '0);
        add_row(mk_beat(ACT_TICK, 32'd9, 1'b1, 8'd0, 16'd0, 32'd0, 8'h00, 1'b0), 1'b0, '0);

        // hold reset, release at an edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            offer(directed[i].b, pick_gap(), directed[i].typed, directed[i].res);
        drain_results();

        // random beats: a stretch with no idling, and one full drain midway
        sim_ms = 32'd50;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            steady = (n >= 150 && n < 210);
            if (n == 300)
                drain_results();
            offer(random_beat(), steady ? 0 : pick_gap(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        // wait out the last results and any stray beat
        while (want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_cnt == 0 && want_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
